### rtl/head_position_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the head position filter
// Shared implication checks, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEAD_POSITION_FILTER_ASSERT_SVH
`define HEAD_POSITION_FILTER_ASSERT_SVH

// Same-cycle implication.
`define HPF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("head position filter check failed");

// Next-cycle implication.
`define HPF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("head position filter check failed");

`endif

### rtl/hpf_pkg.sv
// ----------------------------------------------------------------------------
// hpf_pkg
// Types, constants and command structures of the head position filter.
// ----------------------------------------------------------------------------
package hpf_pkg;

	localparam int WINDOW_LEN  = 5;
	localparam int MAX_REJECTS = 6;

	localparam int IDX_W  = $clog2(WINDOW_LEN);
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int REJ_W  = $clog2(MAX_REJECTS + 1);

	localparam int DIV_W = 30;
	localparam int CNT_W = $clog2(DIV_W);

	localparam int SPAN_MIN = 32;

	localparam logic signed [31:0] POS_MAX = 32'sd8388607;
	localparam logic signed [31:0] POS_MIN = -32'sd8388608;
	localparam logic [50:0] GATE_R2 = 51'd360000;

	localparam logic [2:0] CFG_FOCAL  = 3'd0;
	localparam logic [2:0] CFG_WIDTH  = 3'd1;
	localparam logic [2:0] CFG_HEIGHT = 3'd2;
	localparam logic [2:0] CFG_MIRROR = 3'd3;
	localparam logic [2:0] CFG_SPAN   = 3'd4;

	localparam logic [15:0] FOCAL_RST  = 16'd9835;
	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;
	localparam logic [11:0] SPAN_RST   = 12'd630;

	typedef logic [WINDOW_LEN-1:0][15:0] win_t;

	typedef enum logic [1:0] {
		DIV_DIST,
		DIV_RIGHT,
		DIV_UP
	} div_sel_t;

	typedef struct packed {
		logic             push;
		logic             med_en;
		logic [IDX_W-1:0] med_idx;
		logic             div_load;
		logic             div_step;
		logic             div_store;
		div_sel_t         div_sel;
		logic             sq_en;
		logic             decide;
	} cmd_t;

	typedef struct packed {
		logic span_ok;
		logic out_busy;
	} stat_t;

endpackage

### rtl/hpf_if.sv
// ----------------------------------------------------------------------------
// hpf_if
// Observation and position channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface obs_if;
	logic        valid;
	logic        ready;
	logic [15:0] obs_x;
	logic [15:0] obs_y;
	logic [15:0] obs_span;

	modport source (output valid, obs_x, obs_y, obs_span, input ready);
	modport sink (input valid, obs_x, obs_y, obs_span, output ready);
endinterface

interface pos_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pos_right;
	logic signed [23:0] pos_up;
	logic [22:0]        distance;

	modport source (output valid, pos_right, pos_up, distance, input ready);
	modport sink (input valid, pos_right, pos_up, distance, output ready);
endinterface

### rtl/hpf_ctrl.sv
// ----------------------------------------------------------------------------
// hpf_ctrl
// Sequencer: median scan, three shared divisions, gate squares and decision.
// ----------------------------------------------------------------------------
module hpf_ctrl
	import hpf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MED,
		S_DLOAD,
		S_DRUN,
		S_DSTORE,
		S_SQ,
		S_DECIDE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	div_sel_t         sel_q;

	always_comb begin
		cmd = '0;
		in_ready = (state_q == S_IDLE);
		cmd.push = in_ready && in_valid && stat.span_ok;
		cmd.med_idx = cnt_q[IDX_W-1:0];
		cmd.div_sel = sel_q;
		unique case (state_q)
			S_MED:    cmd.med_en = 1'b1;
			S_DLOAD:  cmd.div_load = 1'b1;
			S_DRUN:   cmd.div_step = 1'b1;
			S_DSTORE: cmd.div_store = 1'b1;
			S_SQ:     cmd.sq_en = 1'b1;
			S_DECIDE: cmd.decide = !stat.out_busy;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			sel_q <= DIV_DIST;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.push) begin
						state_q <= S_MED;
						cnt_q <= '0;
					end
				end
				S_MED: begin
					if (cnt_q == CNT_W'(WINDOW_LEN - 1)) begin
						state_q <= S_DLOAD;
						cnt_q <= '0;
						sel_q <= DIV_DIST;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DLOAD: state_q <= S_DRUN;
				S_DRUN: begin
					if (cnt_q == CNT_W'(DIV_W - 1)) begin
						state_q <= S_DSTORE;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DSTORE: begin
					unique case (sel_q)
						DIV_DIST: begin
							sel_q <= DIV_RIGHT;
							state_q <= S_DLOAD;
						end
						DIV_RIGHT: begin
							sel_q <= DIV_UP;
							state_q <= S_DLOAD;
						end
						default: state_q <= S_SQ;
					endcase
				end
				S_SQ: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/hpf_datapath.sv
// ----------------------------------------------------------------------------
// hpf_datapath
// Registers, median windows, shared restoring divider, spike gate, output.
// ----------------------------------------------------------------------------
`include "head_position_filter_assert.svh"

module hpf_datapath
	import hpf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [15:0]        obs_x,
	input  logic [15:0]        obs_y,
	input  logic [15:0]        obs_span,
	input  cmd_t               cmd,
	output stat_t              stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] pos_right,
	output logic signed [23:0] pos_up,
	output logic [22:0]        distance
);

	logic [15:0] focal_q;
	logic [12:0] img_w_q;
	logic [12:0] img_h_q;
	logic        mirror_q;
	logic [11:0] rspan_q;

	win_t              win_x_q, win_y_q, win_s_q;
	logic [FILL_W-1:0] fill_q;
	logic [15:0]       med_x_q, med_y_q, med_s_q;

	logic [15:0]      rem_q;
	logic [DIV_W-1:0] quo_q;
	logic             neg_q;

	logic signed [23:0] res_right_q, res_up_q;
	logic [22:0]        res_dist_q;
	logic [49:0]        sq_r_q, sq_u_q;

	logic signed [23:0] last_right_q, last_up_q;
	logic [22:0]        last_dist_q;
	logic               have_last_q;
	logic [REJ_W-1:0]   reject_q;

	logic               out_valid_q;
	logic signed [23:0] out_right_q, out_up_q;
	logic [22:0]        out_dist_q;

	function automatic logic is_median(win_t w, logic [IDX_W-1:0] ci, logic [FILL_W-1:0] n);
		logic [FILL_W-1:0] rank;
		rank = '0;
		for (int j = 0; j < WINDOW_LEN; j++) begin
			if (FILL_W'(j) < n && (w[j] < w[ci] || (w[j] == w[ci] && IDX_W'(j) < ci))) begin
				rank = rank + 1'b1;
			end
		end
		return (FILL_W'(ci) < n) && (rank == (n >> 1));
	endfunction

	logic signed [17:0] factor;
	logic signed [31:0] prod, num, mag;
	logic [DIV_W-1:0]   div_num;
	logic [16:0]        trial;
	logic               fits;
	logic signed [31:0] qs;
	logic signed [24:0] dr, du;
	logic signed [49:0] dr_sq, du_sq;
	logic               gate_on, bad;
	logic [50:0]        d2;
	logic [33:0]        dist_100, last_118, dist_1000, last_847;

	always_comb begin
		unique case (cmd.div_sel)
			DIV_DIST:  factor = $signed({2'b00, focal_q});
			DIV_RIGHT: factor = $signed({2'b00, med_x_q}) - $signed({2'b00, img_w_q, 3'b000});
			default:   factor = $signed({2'b00, med_y_q}) - $signed({2'b00, img_h_q, 3'b000});
		endcase
		prod = 32'(factor) * 32'($signed({1'b0, rspan_q}));
		unique case (cmd.div_sel)
			DIV_DIST:  num = prod;
			DIV_RIGHT: num = mirror_q ? prod : -prod;
			default:   num = -prod;
		endcase
		mag = num[31] ? -num : num;
		div_num = DIV_W'(mag) + DIV_W'(med_s_q >> 1);

		trial = {rem_q, quo_q[DIV_W-1]};
		fits = trial >= {1'b0, med_s_q};

		qs = neg_q ? -$signed(32'(quo_q)) : $signed(32'(quo_q));

		dr = 25'(res_right_q) - 25'(last_right_q);
		du = 25'(res_up_q) - 25'(last_up_q);
		dr_sq = dr * dr;
		du_sq = du * du;

		gate_on = have_last_q && (reject_q < REJ_W'(MAX_REJECTS));
		d2 = 51'(sq_r_q) + 51'(sq_u_q);
		dist_100 = 34'(res_dist_q) * 34'd100;
		last_118 = 34'(last_dist_q) * 34'd118;
		dist_1000 = 34'(res_dist_q) * 34'd1000;
		last_847 = 34'(last_dist_q) * 34'd847;
		bad = (d2 > GATE_R2) ||
			(last_dist_q > 23'd10 && (dist_100 > last_118 || dist_1000 < last_847));

		stat.span_ok = obs_span > 16'(SPAN_MIN);
		stat.out_busy = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RST;
			img_w_q <= WIDTH_RST;
			img_h_q <= HEIGHT_RST;
			mirror_q <= 1'b0;
			rspan_q <= SPAN_RST;
			fill_q <= '0;
			last_right_q <= '0;
			last_up_q <= '0;
			last_dist_q <= '0;
			have_last_q <= 1'b0;
			reject_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FOCAL:  focal_q <= cfg_data;
					CFG_WIDTH:  img_w_q <= cfg_data[12:0];
					CFG_HEIGHT: img_h_q <= cfg_data[12:0];
					CFG_MIRROR: mirror_q <= cfg_data[0];
					CFG_SPAN:   rspan_q <= cfg_data[11:0];
					default:    ;
				endcase
			end
			if (cmd.push && fill_q < FILL_W'(WINDOW_LEN)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.decide) begin
				if (gate_on && bad) begin
					reject_q <= reject_q + 1'b1;
				end else begin
					reject_q <= '0;
					last_right_q <= res_right_q;
					last_up_q <= res_up_q;
					last_dist_q <= res_dist_q;
					have_last_q <= 1'b1;
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (fill_q < FILL_W'(WINDOW_LEN)) begin
				win_x_q[fill_q[IDX_W-1:0]] <= obs_x;
				win_y_q[fill_q[IDX_W-1:0]] <= obs_y;
				win_s_q[fill_q[IDX_W-1:0]] <= obs_span;
			end else begin
				for (int i = 0; i < WINDOW_LEN - 1; i++) begin
					win_x_q[i] <= win_x_q[i+1];
					win_y_q[i] <= win_y_q[i+1];
					win_s_q[i] <= win_s_q[i+1];
				end
				win_x_q[WINDOW_LEN-1] <= obs_x;
				win_y_q[WINDOW_LEN-1] <= obs_y;
				win_s_q[WINDOW_LEN-1] <= obs_span;
			end
		end
		if (cmd.med_en) begin
			if (is_median(win_x_q, cmd.med_idx, fill_q)) med_x_q <= win_x_q[cmd.med_idx];
			if (is_median(win_y_q, cmd.med_idx, fill_q)) med_y_q <= win_y_q[cmd.med_idx];
			if (is_median(win_s_q, cmd.med_idx, fill_q)) med_s_q <= win_s_q[cmd.med_idx];
		end
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= div_num;
			neg_q <= num[31];
		end else if (cmd.div_step) begin
			rem_q <= fits ? 16'(trial - {1'b0, med_s_q}) : trial[15:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
		if (cmd.div_store) begin
			unique case (cmd.div_sel)
				DIV_DIST: res_dist_q <= (qs > POS_MAX) ? 23'(POS_MAX) :
					(qs < 0) ? 23'd0 : qs[22:0];
				DIV_RIGHT: res_right_q <= (qs > POS_MAX) ? 24'(POS_MAX) :
					(qs < POS_MIN) ? 24'(POS_MIN) : qs[23:0];
				default: res_up_q <= (qs > POS_MAX) ? 24'(POS_MAX) :
					(qs < POS_MIN) ? 24'(POS_MIN) : qs[23:0];
			endcase
		end
		if (cmd.sq_en) begin
			sq_r_q <= dr_sq;
			sq_u_q <= du_sq;
		end
		if (cmd.decide && !(gate_on && bad)) begin
			out_right_q <= res_right_q;
			out_up_q <= res_up_q;
			out_dist_q <= res_dist_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_right = out_right_q;
	assign pos_up = out_up_q;
	assign distance = out_dist_q;

	`HPF_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= FILL_W'(WINDOW_LEN))
	`HPF_ASSERT_IMP(a_reject_range, 1'b1, reject_q <= REJ_W'(MAX_REJECTS))
	`HPF_ASSERT_IMP(a_decide_free, cmd.decide, !out_valid_q)
	`HPF_ASSERT_NXT(a_push_fill, cmd.push && fill_q < FILL_W'(WINDOW_LEN), fill_q == $past(fill_q) + 1'b1)

endmodule

### rtl/head_position_filter.sv
// ----------------------------------------------------------------------------
// head_position_filter
// Median-filtered face observations turned into a gated metric head position.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// obs      in         obs_x, obs_y, obs_span (1/16 px)
// pos      out        pos_right, pos_up, distance (0.1 mm)
// cfg      in         cfg_we, cfg_index, cfg_data
//
// An observation with a span of 32 or less is taken and gives nothing.
// Any other runs through a median scan, three passes of the shared
// restoring divider, a step of gate squares and a step of decision.
// The decision waits while an earlier result still sits in the output register.
// Reset is asynchronous; it clears control state and loads the configuration defaults.
// ----------------------------------------------------------------------------
module head_position_filter
	import hpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	obs_if.sink         obs,
	pos_if.source       pos
);

	cmd_t  cmd;
	stat_t stat;

	hpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (obs.valid),
		.in_ready (obs.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hpf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.obs_x     (obs.obs_x),
		.obs_y     (obs.obs_y),
		.obs_span  (obs.obs_span),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (pos.valid),
		.out_ready (pos.ready),
		.pos_right (pos.pos_right),
		.pos_up    (pos.pos_up),
		.distance  (pos.distance)
	);

endmodule
